// ===== rtl/core/tskq_pkg.sv =====
`default_nettype none

package tskq_pkg;

  // Operation codes carried in the opcode field of an input transaction.
  typedef enum logic [1:0] {
    OP_INSERT   = 2'd0,
    OP_POP_HEAD = 2'd1,
    OP_POP_TAIL = 2'd2,
    OP_MEMBER   = 2'd3
  } op_t;

  // Status codes reported with every result.
  localparam logic [1:0] STAT_DONE  = 2'd0;
  localparam logic [1:0] STAT_FULL  = 2'd1;
  localparam logic [1:0] STAT_EMPTY = 2'd2;

  // Input transaction payload.
  typedef struct packed {
    op_t         opcode;
    logic [31:0] start_ms;
    logic [31:0] stop_ms;
    logic [31:0] target_position;
  } in_t;

  // Result transaction payload.
  typedef struct packed {
    logic [1:0]  status;
    logic        found;
    logic [31:0] out_start_ms;
    logic [31:0] out_stop_ms;
    logic [31:0] out_position;
    logic [4:0]  occupancy;
    logic        is_empty;
  } out_t;

  // One stored keyframe.
  typedef struct packed {
    logic [31:0] start_ms;
    logic [31:0] stop_ms;
    logic [31:0] position;
  } entry_t;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN_RD,
    ST_SCAN_CMP,
    ST_MOVE_RD,
    ST_MOVE_WR,
    ST_PUT,
    ST_POP_RD,
    ST_POP_TAKE,
    ST_DONE
  } seq_state_t;

endpackage

`default_nettype wire

// ===== rtl/core/time_sorted_keyframe_queue_core.sv =====
`default_nettype none

// Sorted keyframe queue: holds up to CAPACITY entries in ascending start time in a
// one-read, one-write memory and serves insert, pop-head, pop-tail and member-query
// transactions one at a time. A single sequencer drives the memory ports and one
// start-time comparator; every entry read is an address step followed by a
// registered-data step. An insert scans k entries and moves m entries up one slot
// before it writes the new entry; a member query scans until it finds an entry not
// earlier than the key; a pop-head moves the remaining entries down one slot; a
// pop-tail reads only the last entry. A full insert, an empty pop or an empty query
// goes straight to its result. The result sits in an output register, so the next
// transaction is accepted while the previous result waits for out_ready. Reset is
// synchronous and needs no clearing pass.
module time_sorted_keyframe_queue_core #(
  parameter int CAPACITY = 16
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire tskq_pkg::in_t  in_data,
  output logic                out_valid,
  input  wire logic           out_ready,
  output tskq_pkg::out_t      out_data
);

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);

  logic               res_valid;
  logic               res_ready;
  tskq_pkg::out_t     res_data;
  logic               mem_we;
  logic [IDX_W-1:0]   mem_waddr;
  tskq_pkg::entry_t   mem_wdata;
  logic [IDX_W-1:0]   mem_raddr;
  tskq_pkg::entry_t   mem_rdata;

  tskq_seq #(
    .CAPACITY (CAPACITY),
    .IDX_W    (IDX_W),
    .CNT_W    (CNT_W)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_data  (res_data),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  tskq_mem #(
    .DEPTH  (CAPACITY),
    .ADDR_W (IDX_W)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // The output register takes a new result when it is empty or being drained.
  assign res_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_data <= res_data;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/tskq_mem.sv =====
`default_nettype none

module tskq_mem #(
  parameter int DEPTH  = 16,
  parameter int ADDR_W = 4
) (
  input  wire logic                clk,
  input  wire logic                we,
  input  wire logic [ADDR_W-1:0]   waddr,
  input  wire tskq_pkg::entry_t    wdata,
  input  wire logic [ADDR_W-1:0]   raddr,
  output tskq_pkg::entry_t         rdata
);

  tskq_pkg::entry_t mem [DEPTH];

  // Single write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Single read port with registered data.
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== rtl/core/tskq_seq.sv =====
`default_nettype none

module tskq_seq #(
  parameter int CAPACITY = 16,
  parameter int IDX_W    = 4,
  parameter int CNT_W    = 5
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire tskq_pkg::in_t     in_data,
  output logic                   res_valid,
  input  wire logic              res_ready,
  output tskq_pkg::out_t         res_data,
  output logic                   mem_we,
  output logic [IDX_W-1:0]       mem_waddr,
  output tskq_pkg::entry_t       mem_wdata,
  output logic [IDX_W-1:0]       mem_raddr,
  input  wire tskq_pkg::entry_t  mem_rdata
);

  localparam logic [CNT_W-1:0] CAP = CNT_W'(CAPACITY);
  localparam logic [CNT_W-1:0] ONE = CNT_W'(1);

  tskq_pkg::seq_state_t state;
  tskq_pkg::seq_state_t state_next;

  tskq_pkg::op_t    op;
  logic [31:0]      key;
  logic [31:0]      stop_val;
  logic [31:0]      pos_val;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] idx;
  logic [CNT_W-1:0] src;
  tskq_pkg::out_t   res;
  tskq_pkg::out_t   res_init;

  logic [CNT_W-1:0] cnt_inc;
  logic [CNT_W-1:0] cnt_dec;
  logic [CNT_W-1:0] idx_inc;
  logic [CNT_W-1:0] src_inc;
  logic [CNT_W-1:0] src_dec;
  logic [CNT_W+4:0] occ_wide;
  logic             is_full;
  logic             is_zero;
  logic             key_lt;
  logic             key_eq;

  assign cnt_inc  = count + ONE;
  assign cnt_dec  = count - ONE;
  assign idx_inc  = idx + ONE;
  assign src_inc  = src + ONE;
  assign src_dec  = src - ONE;
  assign occ_wide = {5'd0, count};
  assign is_full  = (count == CAP);
  assign is_zero  = (count == '0);

  // Shared compare unit: stored start time against the search key.
  assign key_lt = (mem_rdata.start_ms < key);
  assign key_eq = (mem_rdata.start_ms == key);

  // Next-state logic.
  always_comb begin
    state_next = state;
    unique case (state)
      tskq_pkg::ST_IDLE: begin
        if (in_valid) begin
          unique case (in_data.opcode)
            tskq_pkg::OP_INSERT: begin
              if (is_full) begin
                state_next = tskq_pkg::ST_DONE;
              end else if (is_zero) begin
                state_next = tskq_pkg::ST_PUT;
              end else begin
                state_next = tskq_pkg::ST_SCAN_RD;
              end
            end
            tskq_pkg::OP_POP_HEAD, tskq_pkg::OP_POP_TAIL: begin
              state_next = is_zero ? tskq_pkg::ST_DONE : tskq_pkg::ST_POP_RD;
            end
            tskq_pkg::OP_MEMBER: begin
              state_next = is_zero ? tskq_pkg::ST_DONE : tskq_pkg::ST_SCAN_RD;
            end
            default: state_next = tskq_pkg::ST_DONE;
          endcase
        end
      end
      tskq_pkg::ST_SCAN_RD: state_next = tskq_pkg::ST_SCAN_CMP;
      tskq_pkg::ST_SCAN_CMP: begin
        if (key_lt) begin
          if (idx_inc == count) begin
            state_next = (op == tskq_pkg::OP_INSERT) ? tskq_pkg::ST_PUT : tskq_pkg::ST_DONE;
          end else begin
            state_next = tskq_pkg::ST_SCAN_RD;
          end
        end else begin
          state_next = (op == tskq_pkg::OP_INSERT) ? tskq_pkg::ST_MOVE_RD : tskq_pkg::ST_DONE;
        end
      end
      tskq_pkg::ST_MOVE_RD: state_next = tskq_pkg::ST_MOVE_WR;
      tskq_pkg::ST_MOVE_WR: begin
        if (op == tskq_pkg::OP_INSERT) begin
          state_next = (src == idx) ? tskq_pkg::ST_PUT : tskq_pkg::ST_MOVE_RD;
        end else begin
          state_next = (src == count) ? tskq_pkg::ST_DONE : tskq_pkg::ST_MOVE_RD;
        end
      end
      tskq_pkg::ST_PUT:    state_next = tskq_pkg::ST_DONE;
      tskq_pkg::ST_POP_RD: state_next = tskq_pkg::ST_POP_TAKE;
      tskq_pkg::ST_POP_TAKE: begin
        if (op == tskq_pkg::OP_POP_HEAD && cnt_dec != '0) begin
          state_next = tskq_pkg::ST_MOVE_RD;
        end else begin
          state_next = tskq_pkg::ST_DONE;
        end
      end
      tskq_pkg::ST_DONE: begin
        if (res_ready) begin
          state_next = tskq_pkg::ST_IDLE;
        end
      end
      default: state_next = tskq_pkg::ST_IDLE;
    endcase
  end

  // Output and memory-port logic.
  always_comb begin
    in_ready  = 1'b0;
    res_valid = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = mem_rdata;
    mem_raddr = '0;
    unique case (state)
      tskq_pkg::ST_IDLE:     in_ready = 1'b1;
      tskq_pkg::ST_SCAN_RD:  mem_raddr = idx[IDX_W-1:0];
      tskq_pkg::ST_MOVE_RD:  mem_raddr = src[IDX_W-1:0];
      tskq_pkg::ST_MOVE_WR: begin
        mem_we    = 1'b1;
        mem_waddr = (op == tskq_pkg::OP_INSERT) ? src_inc[IDX_W-1:0] : src_dec[IDX_W-1:0];
      end
      tskq_pkg::ST_PUT: begin
        mem_we    = 1'b1;
        mem_waddr = idx[IDX_W-1:0];
        mem_wdata = '{start_ms: key, stop_ms: stop_val, position: pos_val};
      end
      tskq_pkg::ST_POP_RD: begin
        mem_raddr = (op == tskq_pkg::OP_POP_HEAD) ? '0 : cnt_dec[IDX_W-1:0];
      end
      tskq_pkg::ST_DONE:     res_valid = 1'b1;
      default: ;
    endcase
  end

  // The result carries the occupancy as it stands after the operation.
  always_comb begin
    res_data           = res;
    res_data.occupancy = occ_wide[4:0];
    res_data.is_empty  = is_zero;
  end

  // Status already known at acceptance: a dropped insert or a pop on an empty queue.
  always_comb begin
    res_init = '0;
    if (in_data.opcode == tskq_pkg::OP_INSERT && is_full) begin
      res_init.status = tskq_pkg::STAT_FULL;
    end else if ((in_data.opcode == tskq_pkg::OP_POP_HEAD ||
                  in_data.opcode == tskq_pkg::OP_POP_TAIL) && is_zero) begin
      res_init.status = tskq_pkg::STAT_EMPTY;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tskq_pkg::ST_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      case (state)
        tskq_pkg::ST_PUT:      count <= cnt_inc;
        tskq_pkg::ST_POP_TAKE: count <= cnt_dec;
        default: ;
      endcase
    end
  end

  // Operand, index and result registers.
  always_ff @(posedge clk) begin
    case (state)
      tskq_pkg::ST_IDLE: begin
        if (in_valid) begin
          op       <= in_data.opcode;
          key      <= in_data.start_ms;
          stop_val <= in_data.stop_ms;
          pos_val  <= in_data.target_position;
          idx      <= '0;
          res      <= res_init;
        end
      end
      tskq_pkg::ST_SCAN_CMP: begin
        if (key_lt) begin
          idx <= idx_inc;
        end else if (op == tskq_pkg::OP_INSERT) begin
          src <= cnt_dec;
        end else if (key_eq) begin
          res.found <= 1'b1;
        end
      end
      tskq_pkg::ST_MOVE_WR: begin
        src <= (op == tskq_pkg::OP_INSERT) ? src_dec : src_inc;
      end
      tskq_pkg::ST_POP_TAKE: begin
        res.out_start_ms <= mem_rdata.start_ms;
        res.out_stop_ms  <= mem_rdata.stop_ms;
        res.out_position <= mem_rdata.position;
        src              <= ONE;
      end
      default: ;
    endcase
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst) count <= CAP)
    else $error("entry count exceeds capacity");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> state != tskq_pkg::ST_IDLE)
    else $error("sequencer stayed idle after an accepted transaction");

  a_put_increments: assert property (@(posedge clk) disable iff (rst)
    state == tskq_pkg::ST_PUT |=> count == $past(count) + ONE)
    else $error("insert did not grow the entry count");

  a_found_only_query: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_data.found) |-> op == tskq_pkg::OP_MEMBER)
    else $error("found flag set outside a member query");

  a_full_status: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_data.status == tskq_pkg::STAT_FULL) |-> is_full)
    else $error("full status reported while the queue has room");
`endif

endmodule

`default_nettype wire
